/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge implies b holds at the same edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a holds at an edge implies b holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

/* rtl/sfr_pkg.sv */
// package: frame constants and the result struct of the sensor frame receiver
package sfr_pkg;
	localparam int WORD_COUNT = 10;
	localparam int WORD_W = 16;
	localparam logic [7:0] SYNC_FIRST = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;
	localparam logic [4:0] POS_HUNT = 5'd0;
	localparam logic [4:0] POS_SYNC2 = 5'd1;
	localparam logic [4:0] POS_DATA = 5'd2;
	localparam logic [4:0] POS_CHECK = 5'd22;
	localparam logic [4:0] POS_LAST = 5'd23;
	localparam logic [4:0] FRAME_LEN = 5'd24;
	localparam logic [4:0] FIRST_LOW = 5'd3;

	typedef logic [WORD_COUNT-1:0][WORD_W-1:0] word_vec_t;

	typedef struct packed {
		logic      last_pos;
		logic      valid;
		logic      mismatch;
		word_vec_t words;
	} frame_res_t;
endpackage

/* rtl/sfr_frame_core.sv */
// framing core: sync hunt, byte position, checksum sum and word assembly
`include "assert_macros.svh"

module sfr_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [7:0]        rx_byte,
	output sfr_pkg::frame_res_t res
);
	import sfr_pkg::*;

	logic [4:0]        count_q;
	logic [15:0]       sum_q;
	logic [7:0]        high_q;
	logic [7:0]        chk_hi_q;
	logic [WORD_W-1:0] store_q [WORD_COUNT];

	logic       hunting;
	logic       in_data;
	logic [3:0] widx;
	logic [4:0] pos_off;
	logic [4:0] count_d;

	assign hunting = (count_q == POS_HUNT) || (count_q >= FRAME_LEN);
	assign in_data = (count_q >= POS_DATA) && (count_q < POS_CHECK);
	assign pos_off = count_q - FIRST_LOW;
	assign widx = pos_off[4:1];

	always_comb begin
		if (hunting) begin
			count_d = (rx_byte == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
		end else if (count_q == POS_SYNC2) begin
			count_d = (rx_byte == SYNC_SECOND) ? POS_DATA : POS_HUNT;
		end else if (count_q == POS_LAST) begin
			count_d = POS_HUNT;
		end else begin
			count_d = count_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POS_HUNT;
			sum_q <= '0;
			high_q <= '0;
			chk_hi_q <= '0;
		end else if (in_fire) begin
			count_q <= count_d;
			if (count_q == POS_SYNC2 && rx_byte == SYNC_SECOND) begin
				sum_q <= '0;
			end else if (in_data) begin
				sum_q <= sum_q + {8'd0, rx_byte};
			end
			if (in_data && !count_q[0]) begin
				high_q <= rx_byte;
			end
			if (count_q == POS_CHECK) begin
				chk_hi_q <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data && count_q[0]) begin
			store_q[widx] <= {high_q, rx_byte};
		end
	end

	always_comb begin
		res.last_pos = (count_q == POS_LAST);
		res.valid = in_fire && (count_q == POS_LAST);
		res.mismatch = ({chk_hi_q, rx_byte} != sum_q);
		for (int i = 0; i < WORD_COUNT; i++) begin
			res.words[i] = res.mismatch ? '0 : store_q[i];
		end
	end

	`ASSERT_SAME(a_res_at_last, clk, arst_n, res.valid, count_q == POS_LAST)
	`ASSERT_NEXT(a_resync_after_res, clk, arst_n, res.valid, count_q == POS_HUNT)
	`ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q < FRAME_LEN)
endmodule

/* rtl/sensor_frame_receiver_top.sv */
// top level of the sensor frame receiver: input handshake, core and result register
// Takes one received byte per transfer, one per cycle, and frames 24-byte records:
// sync 0xAA then 0x55, twenty data bytes summed into a 16-bit wrapping checksum and
// paired into ten big-endian words, then the big-endian checksum. On the last byte
// one result is registered: frame_result 0 with the words, or 1 with all words zero
// on a checksum mismatch; then the receiver hunts for sync again. Each byte passes
// through the position counter and checksum adder, and the result appears
// the cycle after the last byte. Input is held off only when the last byte of a frame
// arrives while the previous result is still waiting to be taken.
`include "assert_macros.svh"

module sensor_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        frame_result,
	output logic signed [15:0] roll_raw,
	output logic signed [15:0] pitch_raw,
	output logic signed [15:0] yaw_rate_raw,
	output logic signed [15:0] accel_x_raw,
	output logic signed [15:0] accel_y_raw,
	output logic signed [15:0] accel_z_raw,
	output logic [15:0] timer_word,
	output logic [15:0] temperature_word,
	output logic [15:0] part_word,
	output logic [15:0] device_status_word
);
	import sfr_pkg::*;

	frame_res_t res;
	logic       in_fire;
	logic       out_valid_q;
	logic       mismatch_q;
	word_vec_t  words_q;

	assign in_ready = !(res.last_pos && out_valid_q && !out_ready);
	assign in_fire = in_valid && in_ready;

	sfr_frame_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (rx_byte),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mismatch_q <= res.mismatch;
			words_q <= res.words;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_result = mismatch_q;
	assign roll_raw = words_q[0];
	assign pitch_raw = words_q[1];
	assign yaw_rate_raw = words_q[2];
	assign accel_x_raw = words_q[3];
	assign accel_y_raw = words_q[4];
	assign accel_z_raw = words_q[5];
	assign timer_word = words_q[6];
	assign temperature_word = words_q[7];
	assign part_word = words_q[8];
	assign device_status_word = words_q[9];

	// a waiting result is never overwritten
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, out_valid_q && !out_ready, !res.valid)
	`ASSERT_SAME(a_bad_zero, clk, arst_n, out_valid_q && mismatch_q, words_q == '0)
endmodule
